### design/mm64_pkg.sv
// Shared constants, types and helpers for the MurmurHash64A engine.
// Used by mm64_ctrl, mm64_dpath and the murmur64a_hash top level.
`timescale 1ns / 1ps
`default_nettype none

package mm64_pkg;

   localparam logic [63:0] MUL_C   = 64'hc6a4a7935bd1e995;
   localparam int          SHIFT_R = 47;
   localparam int          ADDR_W  = 4;

   // Datapath operation codes issued by the controller.
   localparam logic [3:0] DP_NONE     = 4'd0;
   localparam logic [3:0] DP_LOAD     = 4'd1;
   localparam logic [3:0] DP_MOP_LEN  = 4'd2;
   localparam logic [3:0] DP_WB_SEED  = 4'd3;
   localparam logic [3:0] DP_MOP_WORD = 4'd4;
   localparam logic [3:0] DP_MOP_TAIL = 4'd5;
   localparam logic [3:0] DP_WB_K1    = 4'd6;
   localparam logic [3:0] DP_WB_K2    = 4'd7;
   localparam logic [3:0] DP_WB_H     = 4'd8;
   localparam logic [3:0] DP_MOP_FIN  = 4'd9;
   localparam logic [3:0] DP_WB_OUT   = 4'd10;

   typedef struct packed {
      logic [3:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic zero;
      logic last;
      logic out_busy;
   } dp_status_type;

   // Byte mask that keeps the low nbytes bytes of a word.
   function automatic logic [63:0] tail_mask(input logic [2:0] nbytes);
      logic [63:0] mask;
      mask = '0;
      for (int i = 0; i < 8; i++) begin
         if (3'(i) < nbytes) begin
            mask[i*8 +: 8] = 8'hff;
         end
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

### design/mm64_dpath.sv
// Datapath of the MurmurHash64A engine: item registers, running hash,
// a shared two-stage 64-bit multiplier by the constant, and the result register.
// Depends on mm64_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm64_dpath
   import mm64_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   input  wire logic [63:0]   seed,
   input  wire logic [63:0]   req_data_word,
   input  wire logic [3:0]    req_valid_bytes,
   input  wire logic          req_last_word,
   input  wire logic [15:0]   req_key_length,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [63:0]        rsp_hash_value
);

   logic [63:0] word_ff, word_in;
   logic [3:0]  nb_ff, nb_in;
   logic        last_ff, last_in;
   logic [15:0] len_ff, len_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] mop_ff, mop_in;
   logic [63:0] pp0_ff, pp0_in;
   logic [31:0] pp1_ff, pp1_in;
   logic [31:0] pp2_ff, pp2_in;
   logic [63:0] hash_ff, hash_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] cross_sum;
   logic [63:0] prod;

   // First multiplier stage: the three partial products that reach the low
   // 64 bits of mop times the constant.
   assign pp0_in = {32'b0, mop_ff[31:0]} * {32'b0, MUL_C[31:0]};
   assign pp1_in = 32'(mop_ff[31:0] * MUL_C[63:32]);
   assign pp2_in = 32'(mop_ff[63:32] * MUL_C[31:0]);

   // Second stage: fold the cross terms into the upper half.
   assign cross_sum = pp1_ff + pp2_ff;
   assign prod      = pp0_ff + {cross_sum, 32'b0};

   always_comb begin
      word_in      = word_ff;
      nb_in        = nb_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      h_in         = h_ff;
      mop_in       = mop_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (cmd.op)
         DP_LOAD: begin
            word_in = req_data_word;
            nb_in   = req_valid_bytes;
            last_in = req_last_word;
            len_in  = req_key_length;
         end
         DP_MOP_LEN:  mop_in = {48'b0, len_ff};
         DP_WB_SEED:  h_in   = seed ^ prod;
         DP_MOP_WORD: mop_in = word_ff;
         DP_MOP_TAIL: mop_in = h_ff ^ (word_ff & tail_mask(nb_ff[2:0]));
         DP_WB_K1:    mop_in = prod ^ (prod >> SHIFT_R);
         DP_WB_K2:    mop_in = h_ff ^ prod;
         DP_WB_H:     h_in   = prod;
         DP_MOP_FIN:  mop_in = h_ff ^ (h_ff >> SHIFT_R);
         DP_WB_OUT: begin
            hash_in      = prod ^ (prod >> SHIFT_R);
            h_in         = '0;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      nb_ff   <= nb_in;
      last_ff <= last_in;
      len_ff  <= len_in;
      mop_ff  <= mop_in;
      pp0_ff  <= pp0_in;
      pp1_ff  <= pp1_in;
      pp2_ff  <= pp2_in;
      hash_ff <= hash_in;
   end

   // Counts of eight and above behave as a full word.
   assign status.full     = nb_ff[3];
   assign status.zero     = (nb_ff == 4'd0);
   assign status.last     = last_ff;
   assign status.out_busy = rsp_valid_ff & rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

endmodule

`default_nettype wire

### design/mm64_ctrl.sv
// Controller of the MurmurHash64A engine: sequences the shared multiplier
// through the start value, word mix, tail and finalizer. Depends on mm64_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm64_ctrl
   import mm64_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_LEN_W = 4'd2;
   localparam logic [3:0] S_LEN_B = 4'd3;
   localparam logic [3:0] S_PREP  = 4'd4;
   localparam logic [3:0] S_K1_W  = 4'd5;
   localparam logic [3:0] S_K1_B  = 4'd6;
   localparam logic [3:0] S_K2_W  = 4'd7;
   localparam logic [3:0] S_K2_B  = 4'd8;
   localparam logic [3:0] S_H_W   = 4'd9;
   localparam logic [3:0] S_H_B   = 4'd10;
   localparam logic [3:0] S_FCHK  = 4'd11;
   localparam logic [3:0] S_F_W   = 4'd12;
   localparam logic [3:0] S_F_B   = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       in_key_ff, in_key_in;

   // Each _W state lets the multiplier register its partial products for
   // the operand written in the state before; the _B state uses the product.
   always_comb begin
      state_in  = state_ff;
      in_key_in = in_key_ff;
      cmd.op    = DP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = S_START;
            end
         end
         S_START: begin
            if (in_key_ff) begin
               state_in = S_PREP;
            end else begin
               cmd.op   = DP_MOP_LEN;
               state_in = S_LEN_W;
            end
         end
         S_LEN_W: state_in = S_LEN_B;
         S_LEN_B: begin
            cmd.op   = DP_WB_SEED;
            state_in = S_PREP;
         end
         S_PREP: begin
            if (status.full) begin
               cmd.op   = DP_MOP_WORD;
               state_in = S_K1_W;
            end else if (status.zero) begin
               state_in = S_FCHK;
            end else begin
               cmd.op   = DP_MOP_TAIL;
               state_in = S_H_W;
            end
         end
         S_K1_W: state_in = S_K1_B;
         S_K1_B: begin
            cmd.op   = DP_WB_K1;
            state_in = S_K2_W;
         end
         S_K2_W: state_in = S_K2_B;
         S_K2_B: begin
            cmd.op   = DP_WB_K2;
            state_in = S_H_W;
         end
         S_H_W: state_in = S_H_B;
         S_H_B: begin
            cmd.op   = DP_WB_H;
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (status.last) begin
               cmd.op   = DP_MOP_FIN;
               state_in = S_F_W;
            end else begin
               in_key_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_F_W: state_in = S_F_B;
         S_F_B: begin
            // Hold here until the previous result has left the output register.
            if (!status.out_busy) begin
               cmd.op    = DP_WB_OUT;
               in_key_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         in_key_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_key_ff <= in_key_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

### design/murmur64a_hash.sv
// MurmurHash64A engine, one 64-bit key word per input beat.
// A new word is accepted only once the previous one is done: each of
// up to five products per item passes a shared two-stage multiplier in turn.
// The hash is registered from the last product and is held until taken.
// Synchronous active-high reset clears the controller, the running hash,
// the result valid flag and the seed register.
`timescale 1ns / 1ps
`default_nettype none

module murmur64a_hash
   import mm64_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [63:0]       req_data_word,
   input  wire logic [3:0]        req_valid_bytes,
   input  wire logic              req_last_word,
   input  wire logic [15:0]       req_key_length,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [63:0]            rsp_hash_value,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [63:0]       pwdata,
   output logic [63:0]            prdata,
   output logic                   pready
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [63:0]   seed_ff, seed_in;
   logic          seed_sel;

   // The seed is the only register; it answers at every address from 0 to 7 (top bit clear).
   assign seed_sel = ~paddr[ADDR_W-1];
   assign pready   = 1'b1;
   assign prdata   = seed_sel ? seed_ff : '0;

   always_comb begin
      seed_in = seed_ff;
      if (psel && penable && pwrite && pready && seed_sel) begin
         seed_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mm64_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mm64_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .seed            (seed_ff),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last_word   (req_last_word),
      .req_key_length  (req_key_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hash_value  (rsp_hash_value)
   );

endmodule

`default_nettype wire
